[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the console engine datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_ALWAYS(label, clk, rst, !(cond), msg)

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)

`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[rtl/tccw_pkg.sv]
// ----------------------------------------------------------------------------
// tccw_pkg
// Constants, types and control structs of the text console cell writer
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int COPY_COUNT = COLUMNS * (ROWS - 1);

   localparam int CMD_W  = 2;
   localparam int CHAR_W = 8;
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;

   typedef logic [CMD_W-1:0]  cmd_code_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;

   localparam cmd_code_type CMD_PUT   = 2'd0;
   localparam cmd_code_type CMD_READ  = 2'd1;
   localparam cmd_code_type CMD_CLEAR = 2'd2;

   localparam char_type ATTRIBUTE       = 8'h07;
   localparam char_type CH_SPACE        = 8'h20;
   localparam char_type CH_NEWLINE      = 8'h0A;
   localparam char_type CH_RETURN       = 8'h0D;
   localparam char_type CH_BACKSPACE    = 8'h08;
   localparam char_type CH_FIRST_PRINT  = 8'd32;
   localparam cell_type BLANK_CELL      = {ATTRIBUTE, CH_SPACE};

   typedef enum logic [2:0] {
      ST_INIT,
      ST_INIT_DRAIN,
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_SCROLL,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      KIND_DONE,
      KIND_READ,
      KIND_CLEAR,
      KIND_SCROLL
   } kind_type;

   typedef struct packed {
      logic accept;
      logic sweep;
      logic sweep_blank;
      logic load_rsp;
      logic rsp_from_read;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     rsp_free;
      logic     sweep_last;
   } dp_sts_type;

endpackage

[rtl/tccw_channels.sv]
// ----------------------------------------------------------------------------
// tccw_channels
// Request and response channel interfaces of the console engine
// ----------------------------------------------------------------------------
interface tccw_req_if;
   import tccw_pkg::*;

   logic         valid;
   logic         ready;
   cmd_code_type command;
   char_type     char_code;
   addr_type     cell_address;

   modport source (output valid, command, char_code, cell_address, input ready);
   modport sink   (input valid, command, char_code, cell_address, output ready);
endinterface

interface tccw_rsp_if;
   import tccw_pkg::*;

   logic     valid;
   logic     ready;
   cell_type cell_data;
   col_type  cursor_column;
   row_type  cursor_row;
   addr_type cursor_offset;

   modport source (output valid, cell_data, cursor_column, cursor_row, cursor_offset,
                   input ready);
   modport sink   (input valid, cell_data, cursor_column, cursor_row, cursor_offset,
                   output ready);
endinterface

[rtl/text_console_cell_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// Text console engine over an 80x25 store of attribute/character cells
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    command, char_code, cell_address
//   rsp_bus   out   valid/ready    cell_data, cursor_column, cursor_row,
//                                  cursor_offset
//
// put without scroll, and unused commands: response loaded at the accept edge
// read: response loaded in ST_READ from the registered read port of the screen store
// clear and scroll: one cell per cycle through the store, then ST_DRAIN loads the response
// after reset a blanking pass (ST_INIT, ST_INIT_DRAIN) holds req ready low
// one word in flight; req ready waits while an undelivered response is stalled
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit (
   input  logic        clock,
   input  logic        reset,
   tccw_req_if.sink    req_bus,
   tccw_rsp_if.source  rsp_bus
);
   import tccw_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;

   assign req_bus.ready = req_ready;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tccw_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .command      (req_bus.command),
      .char_code    (req_bus.char_code),
      .cell_address (req_bus.cell_address),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_bus      (rsp_bus)
   );

endmodule

[rtl/tccw_ctrl.sv]
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer: accepts words, runs screen sweeps and schedules responses
// ----------------------------------------------------------------------------
module tccw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tccw_pkg::dp_sts_type sts,
   output tccw_pkg::dp_cmd_type cmd
);
   import tccw_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && sts.rsp_free;
   assign accept    = req_ready && req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sts.sweep_last) state_in = ST_INIT_DRAIN;
         end
         ST_INIT_DRAIN: state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               unique case (sts.kind)
                  KIND_DONE:   state_in = ST_IDLE;
                  KIND_READ:   state_in = ST_READ;
                  KIND_CLEAR:  state_in = ST_CLEAR;
                  KIND_SCROLL: state_in = ST_SCROLL;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_CLEAR, ST_SCROLL: begin
            if (sts.sweep_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_IDLE;
         default:  state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd               = '0;
      cmd.accept        = accept;
      cmd.sweep         = (state_ff == ST_INIT) || (state_ff == ST_CLEAR) ||
                          (state_ff == ST_SCROLL);
      cmd.sweep_blank   = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
      cmd.rsp_from_read = (state_ff == ST_READ);
      cmd.load_rsp      = (accept && (sts.kind == KIND_DONE)) ||
                          (state_ff == ST_READ) || (state_ff == ST_DRAIN);
   end

endmodule

[rtl/tccw_dpath.sv]
// ----------------------------------------------------------------------------
// tccw_dpath
// Screen store, cursor registers, sweep pipeline and response register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tccw_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  tccw_pkg::cmd_code_type command,
   input  tccw_pkg::char_type     char_code,
   input  tccw_pkg::addr_type     cell_address,
   input  tccw_pkg::dp_cmd_type   cmd,
   output tccw_pkg::dp_sts_type   sts,
   tccw_rsp_if.source             rsp_bus
);
   import tccw_pkg::*;

   cell_type screen_mem [CELL_COUNT];

   col_type  col_ff, col_in, col_nx;
   row_type  row_ff, row_in, row_nx;
   addr_type offset;
   logic     at_last_row;
   logic     at_last_col;
   kind_type kind;
   logic     put_wr;
   addr_type put_addr;
   cell_type put_data;

   addr_type sweep_ff, sweep_in;
   logic     sweep_last;
   logic     stg_valid_ff;
   addr_type stg_addr_ff;
   logic     stg_blank_ff;

   addr_type rd_addr;
   cell_type rd_data_ff;
   logic     rd_ok_ff, rd_ok_in;

   logic     wr_en;
   addr_type wr_addr;
   cell_type wr_data;

   logic     rsp_valid_ff, rsp_valid_in;
   cell_type rsp_data_ff;
   col_type  rsp_col_ff;
   row_type  rsp_row_ff;
   addr_type rsp_off_ff;

   assign offset      = ADDR_W'(row_ff * COLUMNS) + ADDR_W'(col_ff);
   assign at_last_row = (row_ff == ROW_W'(ROWS - 1));
   assign at_last_col = (col_ff == COL_W'(COLUMNS - 1));

   // decode of the offered word against the current cursor
   always_comb begin
      col_nx   = col_ff;
      row_nx   = row_ff;
      kind     = KIND_DONE;
      put_wr   = 1'b0;
      put_addr = offset;
      put_data = BLANK_CELL;
      unique case (command)
         CMD_PUT: begin
            priority if (char_code == CH_NEWLINE) begin
               col_nx = '0;
               if (at_last_row) kind = KIND_SCROLL;
               else row_nx = row_ff + 1'b1;
            end else if (char_code == CH_RETURN) begin
               col_nx = '0;
            end else if (char_code == CH_BACKSPACE) begin
               if (col_ff != '0) begin
                  col_nx   = col_ff - 1'b1;
                  put_wr   = 1'b1;
                  put_addr = offset - 1'b1;
               end
            end else if (!char_code[CHAR_W-1] && (char_code >= CH_FIRST_PRINT)) begin
               put_wr   = 1'b1;
               put_data = {ATTRIBUTE, char_code};
               if (at_last_col) begin
                  col_nx = '0;
                  if (at_last_row) kind = KIND_SCROLL;
                  else row_nx = row_ff + 1'b1;
               end else begin
                  col_nx = col_ff + 1'b1;
               end
            end else begin
               col_nx = col_ff;
            end
         end
         CMD_READ: kind = KIND_READ;
         CMD_CLEAR: begin
            kind   = KIND_CLEAR;
            col_nx = '0;
            row_nx = '0;
         end
         default: kind = KIND_DONE;
      endcase
   end

   assign col_in   = cmd.accept ? col_nx : col_ff;
   assign row_in   = cmd.accept ? row_nx : row_ff;
   assign rd_ok_in = cmd.accept ? ((command == CMD_READ) &&
                                   (cell_address < ADDR_W'(CELL_COUNT))) : rd_ok_ff;

   // sweep: copy row below into place, or blank
   assign sweep_last = (sweep_ff == ADDR_W'(CELL_COUNT - 1));
   assign sweep_in   = cmd.sweep ? (sweep_last ? '0 : sweep_ff + 1'b1) : sweep_ff;

   always_comb begin
      if (cmd.sweep) begin
         if (sweep_ff < ADDR_W'(COPY_COUNT)) rd_addr = sweep_ff + ADDR_W'(COLUMNS);
         else rd_addr = sweep_ff;
      end else begin
         rd_addr = cell_address;
      end
   end

   always_comb begin
      if (stg_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = stg_addr_ff;
         wr_data = stg_blank_ff ? BLANK_CELL : rd_data_ff;
      end else begin
         wr_en   = cmd.accept && put_wr;
         wr_addr = put_addr;
         wr_data = put_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= screen_mem[rd_addr];
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         sweep_ff     <= '0;
         stg_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         sweep_ff     <= sweep_in;
         stg_valid_ff <= cmd.sweep;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_addr_ff  <= sweep_ff;
      stg_blank_ff <= cmd.sweep_blank || (sweep_ff >= ADDR_W'(COPY_COUNT));
      if (cmd.load_rsp) begin
         rsp_data_ff <= (cmd.rsp_from_read && rd_ok_ff) ? rd_data_ff : '0;
         rsp_col_ff  <= col_in;
         rsp_row_ff  <= row_in;
         rsp_off_ff  <= ADDR_W'(row_in * COLUMNS) + ADDR_W'(col_in);
      end
   end

   assign sts.kind       = kind;
   assign sts.rsp_free   = ~rsp_valid_ff | rsp_bus.ready;
   assign sts.sweep_last = sweep_last;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.cell_data     = rsp_data_ff;
   assign rsp_bus.cursor_column = rsp_col_ff;
   assign rsp_bus.cursor_row    = rsp_row_ff;
   assign rsp_bus.cursor_offset = rsp_off_ff;

   `ASSERT_NEVER(a_wr_clash, clock, reset, stg_valid_ff && cmd.accept, "put during sweep write")
   `ASSERT_NEVER(a_rsp_overrun, clock, reset, cmd.load_rsp && rsp_valid_ff && !rsp_bus.ready, "response overwritten")
   `ASSERT_ALWAYS(a_cursor_range, clock, reset, (int'(row_ff) < ROWS) && (int'(col_ff) < COLUMNS), "cursor off screen")

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console cell writer
//
// A short table of directed commands, followed by 1700 random commands,
// is sent on the request channel. Every accepted word runs through a local
// copy of the screen store and the cursor, and the expected response is queued.
// The checker compares each response with the oldest queued expectation.
// The random part mixes runs of text, newlines, backspaces, ignored bytes,
// reads near the cursor, and rare clears, so that wrap and scroll are reached
// many times. Both sides stall in random bursts, except near the end.
// ----------------------------------------------------------------------------
module testbench;
   import tccw_pkg::*;

   localparam cmd_code_type CMD_UNUSED    = 2'd3;
   localparam char_type     CH_LAST_PRINT = 8'd127;
   localparam int           N_RANDOM      = 1700;
   localparam int           N_CALM        = 150;
   localparam int           N_DIRECTED    = 24;

   typedef struct packed {
      cell_type cell_data;
      col_type  cursor_column;
      row_type  cursor_row;
      addr_type cursor_offset;
   } screen_word_type;

   typedef struct packed {
      cmd_code_type    cmd;
      char_type        ch;
      addr_type        addr;
      logic            pinned;
      screen_word_type want;
   } stim_row_type;

   // directed commands, response typed in where it is obvious
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{CMD_READ,   8'h00,        11'd0,    1'b1, '{BLANK_CELL, 7'd0, 5'd0, 11'd0}},
      '{CMD_READ,   8'hFF,        11'd1999, 1'b1, '{BLANK_CELL, 7'd0, 5'd0, 11'd0}},
      '{CMD_READ,   8'h00,        11'd2047, 1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0}},
      '{CMD_PUT,    8'h41,        11'd0,    1'b1, '{16'h0000,   7'd1, 5'd0, 11'd1}},
      '{CMD_READ,   8'h00,        11'd0,    1'b1, '{16'h0741,   7'd1, 5'd0, 11'd1}},
      '{CMD_PUT,    CH_BACKSPACE, 11'd0,    1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0}},
      '{CMD_READ,   8'h00,        11'd0,    1'b1, '{BLANK_CELL, 7'd0, 5'd0, 11'd0}},
      '{CMD_PUT,    CH_BACKSPACE, 11'd0,    1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0}},
      '{CMD_PUT,    8'h7F,        11'd2047, 1'b1, '{16'h0000,   7'd1, 5'd0, 11'd1}},
      '{CMD_PUT,    CH_SPACE,     11'd0,    1'b1, '{16'h0000,   7'd2, 5'd0, 11'd2}},
      '{CMD_PUT,    8'h80,        11'd0,    1'b1, '{16'h0000,   7'd2, 5'd0, 11'd2}},
      '{CMD_PUT,    8'hFF,        11'd0,    1'b1, '{16'h0000,   7'd2, 5'd0, 11'd2}},
      '{CMD_PUT,    8'h00,        11'd0,    1'b1, '{16'h0000,   7'd2, 5'd0, 11'd2}},
      '{CMD_PUT,    8'h1F,        11'd0,    1'b1, '{16'h0000,   7'd2, 5'd0, 11'd2}},
      '{CMD_PUT,    CH_RETURN,    11'd0,    1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0}},
      '{CMD_PUT,    CH_NEWLINE,   11'd0,    1'b1, '{16'h0000,   7'd0, 5'd1, 11'd80}},
      '{CMD_READ,   8'h00,        11'd0,    1'b1, '{16'h077F,   7'd0, 5'd1, 11'd80}},
      '{CMD_READ,   8'h00,        11'd1,    1'b1, '{BLANK_CELL, 7'd0, 5'd1, 11'd80}},
      '{CMD_UNUSED, 8'hFF,        11'd2047, 1'b1, '{16'h0000,   7'd0, 5'd1, 11'd80}},
      '{CMD_PUT,    8'h7E,        11'd0,    1'b0, '0},
      '{CMD_READ,   8'h00,        11'd80,   1'b0, '0},
      '{CMD_CLEAR,  8'hFF,        11'd2047, 1'b1, '{16'h0000,   7'd0, 5'd0, 11'd0}},
      '{CMD_READ,   8'h00,        11'd80,   1'b1, '{BLANK_CELL, 7'd0, 5'd0, 11'd0}},
      '{CMD_READ,   8'h00,        11'd0,    1'b1, '{BLANK_CELL, 7'd0, 5'd0, 11'd0}}
   };

   logic clock = 1'b0;
   logic reset;

   tccw_req_if req_bus ();
   tccw_rsp_if rsp_bus ();

   text_console_cell_writer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #2 clock = ~clock;

   cell_type        screen_model [CELL_COUNT];
   int              model_col;
   int              model_row;
   screen_word_type pending_words [$];
   int              mismatch_count = 0;
   logic            calm = 1'b0;
   logic            word_pinned;
   screen_word_type pinned_word;
   int              send_quiet = 0;

   function automatic void blank_screen_model();
      for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
   endfunction

   function automatic void advance_row_model();
      model_col = 0;
      model_row++;
      if (model_row >= ROWS) begin
         for (int i = 0; i < COPY_COUNT; i++) screen_model[i] = screen_model[i + COLUMNS];
         for (int i = COPY_COUNT; i < CELL_COUNT; i++) screen_model[i] = BLANK_CELL;
         model_row = ROWS - 1;
      end
   endfunction

   function automatic screen_word_type console_apply(cmd_code_type cmd, char_type ch,
                                                     addr_type addr);
      screen_word_type w;
      w = '0;
      case (cmd)
         CMD_PUT: begin
            if (ch == CH_NEWLINE) begin
               advance_row_model();
            end else if (ch == CH_RETURN) begin
               model_col = 0;
            end else if (ch == CH_BACKSPACE) begin
               if (model_col > 0) begin
                  model_col--;
                  screen_model[model_row * COLUMNS + model_col] = BLANK_CELL;
               end
            end else if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
               screen_model[model_row * COLUMNS + model_col] = {ATTRIBUTE, ch};
               model_col++;
               if (model_col >= COLUMNS) advance_row_model();
            end
         end
         CMD_READ: begin
            if (addr < CELL_COUNT) w.cell_data = screen_model[addr];
         end
         CMD_CLEAR: begin
            blank_screen_model();
            model_col = 0;
            model_row = 0;
         end
         default: ;
      endcase
      w.cursor_column = col_type'(model_col);
      w.cursor_row    = row_type'(model_row);
      w.cursor_offset = addr_type'(model_row * COLUMNS + model_col);
      return w;
   endfunction

   task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
         mismatch_count++;
      end
   endtask

   // response checker and request predictor
   always @(posedge clock) begin
      screen_word_type got;
      screen_word_type want;
      if (reset) begin
         blank_screen_model();
         model_col = 0;
         model_row = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.cell_data, rsp_bus.cursor_column, rsp_bus.cursor_row,
                    rsp_bus.cursor_offset};
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, got %h", $time, got);
               mismatch_count++;
            end else begin
               want = pending_words.pop_front();
               check_field("cell_data", want.cell_data, got.cell_data);
               check_field("cursor_column", want.cursor_column, got.cursor_column);
               check_field("cursor_row", want.cursor_row, got.cursor_row);
               check_field("cursor_offset", want.cursor_offset, got.cursor_offset);
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            want = console_apply(req_bus.command, req_bus.char_code, req_bus.cell_address);
            if (word_pinned) want = pinned_word;
            pending_words.push_back(want);
         end
      end
   end

   // response side stalls
   initial begin
      int stall;
      int quiet;
      stall = 0;
      quiet = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else if (quiet > 0) begin
            rsp_bus.ready <= 1'b1;
            quiet--;
         end else begin
            case ($urandom_range(0, 19))
               0: begin
                  stall = $urandom_range(1, 14) - 1;
                  rsp_bus.ready <= 1'b0;
               end
               1: begin
                  quiet = $urandom_range(20, 200);
                  rsp_bus.ready <= 1'b1;
               end
               default: rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   task automatic send_word(cmd_code_type cmd, char_type ch, addr_type addr,
                            logic pinned, screen_word_type want);
      int gap;
      if (send_quiet > 0) begin
         send_quiet--;
      end else if (!calm && $urandom_range(0, 39) == 0) begin
         send_quiet = $urandom_range(10, 60);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.char_code    <= ch;
      req_bus.cell_address <= addr;
      word_pinned          <= pinned;
      pinned_word          <= want;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_words();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   initial begin
      cmd_code_type cmd;
      char_type     ch;
      addr_type     addr;
      int           pick;
      int           text_left;
      int           near;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_PUT;
      req_bus.char_code    = '0;
      req_bus.cell_address = '0;
      word_pinned          = 1'b0;
      pinned_word          = '0;
      text_left            = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < N_DIRECTED; k++)
         send_word(DIRECTED[k].cmd, DIRECTED[k].ch, DIRECTED[k].addr,
                   DIRECTED[k].pinned, DIRECTED[k].want);
      drain_words();

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM / 2) drain_words();
         if (n == N_RANDOM - N_CALM) calm = 1'b1;
         cmd  = CMD_PUT;
         ch   = char_type'($urandom_range(0, 255));
         addr = addr_type'($urandom_range(0, 2047));
         pick = $urandom_range(0, 99);
         if (text_left == 0 && $urandom_range(0, 24) == 0)
            text_left = $urandom_range(60, 120);
         if (text_left > 0) begin
            // a run of text, often long enough to wrap
            ch = char_type'($urandom_range(32, 127));
            text_left--;
         end else if ($urandom_range(0, 399) == 0) begin
            cmd = CMD_CLEAR;
         end else if (pick < 50) begin
            ch = char_type'($urandom_range(32, 127));
         end else if (pick < 62) begin
            ch = CH_NEWLINE;
         end else if (pick < 65) begin
            ch = CH_RETURN;
         end else if (pick < 71) begin
            ch = CH_BACKSPACE;
         end else if (pick < 75) begin
            // bytes below space (ignored but for newline, return, backspace) and the upper half
            if ($urandom_range(0, 1) == 0) ch = char_type'($urandom_range(0, 31));
            else ch = char_type'($urandom_range(128, 255));
         end else if (pick < 76) begin
            cmd = CMD_UNUSED;
         end else begin
            cmd = CMD_READ;
            case ($urandom_range(0, 4))
               0, 1: begin
                  near = model_row * COLUMNS + model_col - $urandom_range(0, 160);
                  addr = addr_type'(near < 0 ? 0 : near);
               end
               2, 3: addr = addr_type'($urandom_range(0, CELL_COUNT - 1));
               default: addr = addr_type'($urandom_range(CELL_COUNT, 2047));
            endcase
         end
         send_word(cmd, ch, addr, 1'b0, '0);
      end

      drain_words();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #80_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
